[rtl/cpt_pkg.sv]
// Package for the Clarke/Park frame transform unit.
// Holds the command codes, the Clarke coefficients and the sine table generator.
// It has no dependencies and is used by the top level and its testbench.
package cpt_pkg;

    typedef enum logic [1:0] {
        CMD_CLARKE     = 2'd0,
        CMD_PARK       = 2'd1,
        CMD_INV_PARK   = 2'd2,
        CMD_INV_CLARKE = 2'd3
    } cmd_t;

    localparam logic signed [17:0] C_TWO_THIRDS = 18'sd43691;
    localparam logic signed [17:0] C_ONE_THIRD  = 18'sd21845;
    localparam logic signed [17:0] C_INV_SQRT3  = 18'sd37837;
    localparam logic signed [17:0] C_SQRT3_HALF = 18'sd56756;
    localparam logic signed [17:0] C_HALF       = 18'sd32768;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Quarter-wave sine entry k of a table with 2**tbits steps, in Q0.frac.
    function automatic logic [31:0] sine_entry(input int k, input int tbits, input int frac);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        longint      lim;
        longint      r;
        begin
            x    = (64'(k) * HALF_PI_Q30) >> tbits;
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (int n = 1; n <= 12; n++)
            begin
                term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
                if ((n % 2) == 1)
                begin
                    sum = sum - longint'(term);
                end
                else
                begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0)
            begin
                sum = 0;
            end
            r   = (sum + (longint'(1) << (29 - frac))) >>> (30 - frac);
            lim = (longint'(1) << frac) - 1;
            if (r > lim)
            begin
                r = lim;
            end
            sine_entry = 32'(r);
        end
    endfunction

endpackage

[rtl/clarke_park_transform_unit.sv]
// Top level of the Clarke/Park frame transform unit.
// Depends on cpt_pkg for command codes, coefficients and the sine table.
//
// Usage:
// The input channel (in_valid, in_stall) carries one word per transform: a
// command, three samples, and either a phase angle or a sine/cosine pair.
// The output channel (out_valid, out_stall) returns one word with out_x,
// out_y and out_z for each input word, in order.
// A word passes an input register and a result register; its result is
// shown once it reaches the result register, and is taken by the receiver
// at a clock edge on which out_stall is low.
// One word is accepted every cycle while in_stall is low; the rate is set
// by the single pass of lookup, multiply and round between those two registers.
// Sine and cosine for phase-driven words come from a constant quarter-wave
// table, read twice in the same cycle.
// Reset clears both valid flags; no result is shown until a word arrives.
// When the receiver stalls, the result holds, the input register fills, and
// in_stall rises only once both are occupied.
module clarke_park_transform_unit #(
    parameter int SINE_TABLE_BITS = 8,
    parameter int SAMPLE_WIDTH    = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [1:0]                     cmd,
    input  logic signed [SAMPLE_WIDTH-1:0] in_x,
    input  logic signed [SAMPLE_WIDTH-1:0] in_y,
    input  logic signed [SAMPLE_WIDTH-1:0] in_z,
    input  logic                           use_phase,
    input  logic [15:0]                    phase,
    input  logic signed [SAMPLE_WIDTH-1:0] sin_in,
    input  logic signed [SAMPLE_WIDTH-1:0] cos_in,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [SAMPLE_WIDTH:0]   out_x,
    output logic signed [SAMPLE_WIDTH:0]   out_y,
    output logic signed [SAMPLE_WIDTH:0]   out_z
);

    localparam int W      = SAMPLE_WIDTH;
    localparam int F      = SAMPLE_WIDTH - 1;
    localparam int TB     = SINE_TABLE_BITS;
    localparam int QSTEPS = 1 << SINE_TABLE_BITS;
    localparam int CL_W   = SAMPLE_WIDTH + 20;
    localparam int PK_W   = 2 * SAMPLE_WIDTH + 1;
    localparam int ACC_W  = (PK_W + 1 > CL_W) ? PK_W + 1 : CL_W;

    localparam logic signed [CL_W-1:0]  CL_RND  = CL_W'(32768);
    localparam logic signed [PK_W-1:0]  PK_RND  = PK_W'(1) <<< (F - 1);
    localparam logic signed [ACC_W-1:0] OUT_MAX = (ACC_W'(1) <<< W) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] OUT_MIN = -(ACC_W'(1) <<< W);
    localparam logic [14+TB:0]          K_RND   = (15 + TB)'(8192);
    localparam logic [TB:0]             K_TOP   = (TB + 1)'(QSTEPS);

    logic [F-1:0] sine_rom [0:QSTEPS];

    for (genvar k = 0; k <= QSTEPS; k++)
    begin : g_rom
        localparam logic [31:0] ENTRY = cpt_pkg::sine_entry(k, TB, F);
        assign sine_rom[k] = ENTRY[F-1:0];
    end

    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    cpt_pkg::cmd_t         cmd_reg;
    logic signed [W-1:0]   x_reg;
    logic signed [W-1:0]   y_reg;
    logic signed [W-1:0]   z_reg;
    logic                  use_phase_reg;
    logic [15:0]           phase_reg;
    logic signed [W-1:0]   sin_reg;
    logic signed [W-1:0]   cos_reg;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic signed [W:0]     out_x_reg;
    logic signed [W:0]     out_y_reg;
    logic signed [W:0]     out_z_reg;

    logic                  in_take;
    logic                  s1_adv;

    logic [15:0]           cos_phase;
    logic [14+TB:0]        k_sin_wide;
    logic [14+TB:0]        k_cos_wide;
    logic [TB:0]           k_sin;
    logic [TB:0]           k_cos;
    logic [F-1:0]          mag_sin;
    logic [F-1:0]          mag_cos;
    logic signed [W-1:0]   tab_sin;
    logic signed [W-1:0]   tab_cos;
    logic signed [W-1:0]   sin_sel;
    logic signed [W-1:0]   cos_sel;

    logic signed [W:0]     yz_sum;
    logic signed [W:0]     yz_diff;
    logic signed [CL_W-1:0] cl_alpha_sum;
    logic signed [CL_W-1:0] cl_beta_sum;
    logic signed [CL_W-1:0] icl_b_sum;
    logic signed [CL_W-1:0] icl_c_sum;
    logic signed [CL_W-1:0] cl_alpha;
    logic signed [CL_W-1:0] cl_beta;
    logic signed [CL_W-1:0] icl_b;
    logic signed [CL_W-1:0] icl_c;
    logic signed [PK_W-1:0] pk_d_sum;
    logic signed [PK_W-1:0] pk_q_sum;
    logic signed [PK_W-1:0] ipk_a_sum;
    logic signed [PK_W-1:0] ipk_b_sum;
    logic signed [PK_W-1:0] pk_d;
    logic signed [PK_W-1:0] pk_q;
    logic signed [PK_W-1:0] ipk_a;
    logic signed [PK_W-1:0] ipk_b;
    logic signed [ACC_W-1:0] res_x;
    logic signed [ACC_W-1:0] res_y;
    logic signed [ACC_W-1:0] res_z;

    function automatic logic signed [W:0] clamp_out(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] t;
        begin
            t = v;
            if (v > OUT_MAX)
            begin
                t = OUT_MAX;
            end
            else if (v < OUT_MIN)
            begin
                t = OUT_MIN;
            end
            clamp_out = t[W:0];
        end
    endfunction

    assign s1_adv         = !out_valid_reg || !out_stall;
    assign in_stall       = s1_valid_reg && !s1_adv;
    assign in_take        = in_valid && !in_stall;
    assign s1_valid_next  = in_take || (s1_valid_reg && !s1_adv);
    assign out_valid_next = s1_adv ? s1_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            cmd_reg       <= cpt_pkg::cmd_t'(cmd);
            x_reg         <= in_x;
            y_reg         <= in_y;
            z_reg         <= in_z;
            use_phase_reg <= use_phase;
            phase_reg     <= phase;
            sin_reg       <= sin_in;
            cos_reg       <= cos_in;
        end
    end

    // Phase lookup: nearest entry of the quarter-wave table, folded by quadrant.
    always_comb
    begin
        cos_phase  = phase_reg + 16'h4000;
        k_sin_wide = {1'b0, phase_reg[13:0], {TB{1'b0}}} + K_RND;
        k_cos_wide = {1'b0, cos_phase[13:0], {TB{1'b0}}} + K_RND;
        k_sin      = k_sin_wide[14+TB:14];
        k_cos      = k_cos_wide[14+TB:14];
        mag_sin    = phase_reg[14] ? sine_rom[K_TOP - k_sin] : sine_rom[k_sin];
        mag_cos    = cos_phase[14] ? sine_rom[K_TOP - k_cos] : sine_rom[k_cos];
        tab_sin    = phase_reg[15] ? -$signed({1'b0, mag_sin}) : $signed({1'b0, mag_sin});
        tab_cos    = cos_phase[15] ? -$signed({1'b0, mag_cos}) : $signed({1'b0, mag_cos});
        sin_sel    = use_phase_reg ? tab_sin : sin_reg;
        cos_sel    = use_phase_reg ? tab_cos : cos_reg;
    end

    always_comb
    begin
        yz_sum       = (W + 1)'(y_reg) + (W + 1)'(z_reg);
        yz_diff      = (W + 1)'(y_reg) - (W + 1)'(z_reg);
        cl_alpha_sum = CL_W'(cpt_pkg::C_TWO_THIRDS) * CL_W'(x_reg)
                     - CL_W'(cpt_pkg::C_ONE_THIRD) * CL_W'(yz_sum) + CL_RND;
        cl_beta_sum  = CL_W'(cpt_pkg::C_INV_SQRT3) * CL_W'(yz_diff) + CL_RND;
        icl_b_sum    = CL_W'(cpt_pkg::C_SQRT3_HALF) * CL_W'(y_reg)
                     - CL_W'(cpt_pkg::C_HALF) * CL_W'(x_reg) + CL_RND;
        icl_c_sum    = -(CL_W'(cpt_pkg::C_SQRT3_HALF) * CL_W'(y_reg))
                     - CL_W'(cpt_pkg::C_HALF) * CL_W'(x_reg) + CL_RND;
        cl_alpha     = cl_alpha_sum >>> 16;
        cl_beta      = cl_beta_sum >>> 16;
        icl_b        = icl_b_sum >>> 16;
        icl_c        = icl_c_sum >>> 16;

        pk_d_sum     = PK_W'(x_reg) * PK_W'(cos_sel) + PK_W'(y_reg) * PK_W'(sin_sel) + PK_RND;
        pk_q_sum     = PK_W'(y_reg) * PK_W'(cos_sel) - PK_W'(x_reg) * PK_W'(sin_sel) + PK_RND;
        ipk_a_sum    = PK_W'(x_reg) * PK_W'(cos_sel) - PK_W'(y_reg) * PK_W'(sin_sel) + PK_RND;
        ipk_b_sum    = PK_W'(x_reg) * PK_W'(sin_sel) + PK_W'(y_reg) * PK_W'(cos_sel) + PK_RND;
        pk_d         = pk_d_sum >>> F;
        pk_q         = pk_q_sum >>> F;
        ipk_a        = ipk_a_sum >>> F;
        ipk_b        = ipk_b_sum >>> F;

        unique case (cmd_reg)
            cpt_pkg::CMD_CLARKE:
            begin
                res_x = ACC_W'(cl_alpha);
                res_y = ACC_W'(cl_beta);
                res_z = '0;
            end
            cpt_pkg::CMD_PARK:
            begin
                res_x = ACC_W'(pk_d);
                res_y = ACC_W'(pk_q);
                res_z = '0;
            end
            cpt_pkg::CMD_INV_PARK:
            begin
                res_x = ACC_W'(ipk_a);
                res_y = ACC_W'(ipk_b);
                res_z = '0;
            end
            cpt_pkg::CMD_INV_CLARKE:
            begin
                res_x = ACC_W'(x_reg);
                res_y = ACC_W'(icl_b);
                res_z = ACC_W'(icl_c);
            end
            default:
            begin
                res_x = '0;
                res_y = '0;
                res_z = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_valid_reg)
        begin
            out_x_reg <= clamp_out(res_x);
            out_y_reg <= clamp_out(res_y);
            out_z_reg <= clamp_out(res_z);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_z     = out_z_reg;

endmodule

[rtl/cpt_checker.sv]
// Port-level checker for the Clarke/Park frame transform unit.
// Depends on the top level's port list; bound to clarke_park_transform_unit below.
module cpt_checker #(
    parameter int SAMPLE_WIDTH = 16
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_stall,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic signed [SAMPLE_WIDTH:0] out_x,
    input logic signed [SAMPLE_WIDTH:0] out_y,
    input logic signed [SAMPLE_WIDTH:0] out_z
);

    a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("Result word dropped while stalled.");

    a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_x) && $stable(out_y) && $stable(out_z))
        else $error("Result word changed while stalled.");

    a_no_stall_through: assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
        else $error("Input stalled although the receiver is taking words.");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) ##1 !out_stall |=> out_valid)
        else $error("Accepted word did not reach the output in two cycles.");

endmodule

bind clarke_park_transform_unit cpt_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_checker (.*);

[verif/clarke_park_transform_unit_tb.sv]
// Self-checking testbench for clarke_park_transform_unit.
// Depends on cpt_pkg for the command type. It drives directed and random words,
// predicts every result, and checks the returned words in order under random stalls.
module clarke_park_transform_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SW             = 16;
    localparam int TBITS          = 8;
    localparam int TABLE_STEPS    = 1 << TBITS;
    localparam int FRAC           = SW - 1;
    localparam int RANDOM_WORDS   = 750;
    localparam int WATCHDOG_LIMIT = 5000;

    localparam longint K_TWO_THIRDS = 43691;
    localparam longint K_ONE_THIRD  = 21845;
    localparam longint K_INV_SQRT3  = 37837;
    localparam longint K_SQRT3_HALF = 56756;
    localparam longint K_HALF       = 32768;

    typedef struct {
        cpt_pkg::cmd_t         op;
        logic signed [SW-1:0]  a;
        logic signed [SW-1:0]  b;
        logic signed [SW-1:0]  c;
        logic                  by_angle;
        logic [15:0]           angle;
        logic signed [SW-1:0]  sine;
        logic signed [SW-1:0]  cosine;
        logic                  drain_first;
    } xform_word_t;

    typedef struct {
        logic signed [SW:0] x;
        logic signed [SW:0] y;
        logic signed [SW:0] z;
    } frame_result_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    logic [1:0]           cmd       = '0;
    logic signed [SW-1:0] in_x      = '0;
    logic signed [SW-1:0] in_y      = '0;
    logic signed [SW-1:0] in_z      = '0;
    logic                 use_phase = 1'b0;
    logic [15:0]          phase     = '0;
    logic signed [SW-1:0] sin_in    = '0;
    logic signed [SW-1:0] cos_in    = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic signed [SW:0]   out_x;
    logic signed [SW:0]   out_y;
    logic signed [SW:0]   out_z;

    longint        sine_lut [0:TABLE_STEPS];
    xform_word_t   pending_words [$];
    frame_result_t expected_results [$];
    xform_word_t   cur_word;
    frame_result_t want;
    int            mismatch_count = 0;
    int            gap_left       = 0;
    int            burst_left     = 0;
    int            stall_mode     = 0;
    int            mode_left      = 0;
    int            idle_cycles    = 0;

    clarke_park_transform_unit #(
        .SINE_TABLE_BITS(TBITS),
        .SAMPLE_WIDTH   (SW)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .in_x     (in_x),
        .in_y     (in_y),
        .in_z     (in_z),
        .use_phase(use_phase),
        .phase    (phase),
        .sin_in   (sin_in),
        .cos_in   (cos_in),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_x    (out_x),
        .out_y    (out_y),
        .out_z    (out_z)
    );

    always #1 clk = ~clk;

    function automatic longint quarter_sine(int k);
        logic [63:0] ang;
        logic [63:0] ang_sq;
        logic [63:0] term;
        longint      acc;
        longint      r;
        ang    = (64'(k) * 64'd1686629713) / 64'(TABLE_STEPS);
        ang_sq = (ang * ang) >> 30;
        term   = ang;
        acc    = longint'(ang);
        for (int n = 1; n <= 12; n++)
        begin
            term = ((term * ang_sq) >> 30) / 64'((2 * n) * (2 * n + 1));
            if ((n % 2) == 1)
            begin
                acc = acc - longint'(term);
            end
            else
            begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0)
        begin
            acc = 0;
        end
        r = (acc + (longint'(1) << (29 - FRAC))) >>> (30 - FRAC);
        if (r > (longint'(1) << FRAC) - 1)
        begin
            r = (longint'(1) << FRAC) - 1;
        end
        return r;
    endfunction

    function automatic longint angle_sine(logic [15:0] ang);
        int     k;
        longint v;
        k = (int'(ang[13:0]) * TABLE_STEPS + 8192) >> 14;
        if (k > TABLE_STEPS)
        begin
            k = TABLE_STEPS;
        end
        v = ang[14] ? sine_lut[TABLE_STEPS - k] : sine_lut[k];
        return ang[15] ? -v : v;
    endfunction

    function automatic longint round_shift(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic logic signed [SW:0] fit_q2(longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) << SW) - 1;
        lo = -(longint'(1) << SW);
        if (v > hi)
        begin
            v = hi;
        end
        if (v < lo)
        begin
            v = lo;
        end
        return v[SW:0];
    endfunction

    function automatic frame_result_t transform_frame(xform_word_t w);
        longint        a;
        longint        b;
        longint        c;
        longint        s;
        longint        co;
        longint        rx;
        longint        ry;
        longint        rz;
        frame_result_t r;
        a  = w.a;
        b  = w.b;
        c  = w.c;
        rz = 0;
        if (w.by_angle)
        begin
            s  = angle_sine(w.angle);
            co = angle_sine(16'(w.angle + 16'h4000));
        end
        else
        begin
            s  = w.sine;
            co = w.cosine;
        end
        case (w.op)
            cpt_pkg::CMD_CLARKE:
            begin
                rx = round_shift(K_TWO_THIRDS * a - K_ONE_THIRD * b - K_ONE_THIRD * c, 16);
                ry = round_shift(K_INV_SQRT3 * (b - c), 16);
            end
            cpt_pkg::CMD_PARK:
            begin
                rx = round_shift(a * co + b * s, FRAC);
                ry = round_shift(b * co - a * s, FRAC);
            end
            cpt_pkg::CMD_INV_PARK:
            begin
                rx = round_shift(a * co - b * s, FRAC);
                ry = round_shift(a * s + b * co, FRAC);
            end
            default:
            begin
                rx = a;
                ry = round_shift(K_SQRT3_HALF * b - K_HALF * a, 16);
                rz = round_shift(-K_SQRT3_HALF * b - K_HALF * a, 16);
            end
        endcase
        r.x = fit_q2(rx);
        r.y = fit_q2(ry);
        r.z = fit_q2(rz);
        return r;
    endfunction

    function automatic xform_word_t make_word(cpt_pkg::cmd_t op, int a, int b, int c,
                                              logic by_angle, int angle, int sine, int cosine);
        xform_word_t w;
        w.op          = op;
        w.a           = SW'(a);
        w.b           = SW'(b);
        w.c           = SW'(c);
        w.by_angle    = by_angle;
        w.angle       = 16'(angle);
        w.sine        = SW'(sine);
        w.cosine      = SW'(cosine);
        w.drain_first = 1'b0;
        return w;
    endfunction

    function automatic logic signed [SW-1:0] rand_sample();
        case ($urandom_range(0, 11))
            0: return {1'b1, {(SW-1){1'b0}}};
            1: return {1'b0, {(SW-1){1'b1}}};
            2: return '0;
            3: return '1;
            default: return SW'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] rand_angle();
        case ($urandom_range(0, 7))
            0: return 16'($urandom_range(0, 3) * 16384);
            1: return 16'($urandom_range(0, 3) * 16384 + 16383);
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic check_field(string name, logic signed [SW:0] exp_v, logic signed [SW:0] act_v);
        if (act_v !== exp_v)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_results.push_back(transform_frame(cur_word));
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_words.size() == 0)
                begin
                    in_valid <= 1'b0;
                end
                else if (pending_words[0].drain_first && expected_results.size() != 0)
                begin
                    in_valid <= 1'b0;
                end
                else
                begin
                    cur_word  = pending_words.pop_front();
                    cmd       <= cur_word.op;
                    in_x      <= cur_word.a;
                    in_y      <= cur_word.b;
                    in_z      <= cur_word.c;
                    use_phase <= cur_word.by_angle;
                    phase     <= cur_word.angle;
                    sin_in    <= cur_word.sine;
                    cos_in    <= cur_word.cosine;
                    in_valid  <= 1'b1;
                    if (burst_left > 0)
                    begin
                        burst_left--;
                    end
                    if (burst_left == 0)
                    begin
                        if ($urandom_range(0, 4) == 0)
                        begin
                            burst_left = $urandom_range(40, 120);
                            gap_left   = 0;
                        end
                        else
                        begin
                            burst_left = $urandom_range(1, 12);
                            gap_left   = $urandom_range(0, 8);
                        end
                    end
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected word, got x=%0d y=%0d z=%0d",
                             $time, out_x, out_y, out_z);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("out_x", want.x, out_x);
                    check_field("out_y", want.y, out_y);
                    check_field("out_z", want.z, out_z);
                end
            end
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(64, 256);
            end
            else
            begin
                mode_left--;
            end
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                2: out_stall <= ($urandom_range(0, 3) != 0);
                default: out_stall <= ~out_stall;
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial
    begin
        xform_word_t w;
        for (int k = 0; k <= TABLE_STEPS; k++)
        begin
            sine_lut[k] = quarter_sine(k);
        end

        pending_words.push_back(make_word(cpt_pkg::CMD_CLARKE, 0, 0, 0,
                                          1'b0, 0, 0, 0));
        pending_words.push_back(make_word(cpt_pkg::CMD_CLARKE, 32767, -32768, -32768,
                                          1'b1, 65535, -1, 5));
        pending_words.push_back(make_word(cpt_pkg::CMD_CLARKE, -32768, 32767, 32767,
                                          1'b0, 0, 32767, -32768));
        pending_words.push_back(make_word(cpt_pkg::CMD_CLARKE, 32767, 32767, -32768,
                                          1'b0, 0, 0, 0));
        pending_words.push_back(make_word(cpt_pkg::CMD_CLARKE, -32768, -32768, 32767,
                                          1'b0, 0, 0, 0));
        pending_words.push_back(make_word(cpt_pkg::CMD_INV_CLARKE, 32767, 32767, 1234,
                                          1'b1, 0, 0, 0));
        pending_words.push_back(make_word(cpt_pkg::CMD_INV_CLARKE, -32768, -32768, -1,
                                          1'b0, 0, 5, 5));
        pending_words.push_back(make_word(cpt_pkg::CMD_INV_CLARKE, 32767, -32768, 0,
                                          1'b0, 0, 0, 0));
        pending_words.push_back(make_word(cpt_pkg::CMD_INV_CLARKE, -32768, 32767, 0,
                                          1'b0, 0, 0, 0));
        pending_words.push_back(make_word(cpt_pkg::CMD_PARK, -32768, -32768, 77,
                                          1'b0, 0, -32768, -32768));
        pending_words.push_back(make_word(cpt_pkg::CMD_PARK, 32767, 32767, 0,
                                          1'b0, 0, -32768, -32768));
        pending_words.push_back(make_word(cpt_pkg::CMD_PARK, 32767, -32768, 0,
                                          1'b0, 0, 32767, 32767));
        pending_words.push_back(make_word(cpt_pkg::CMD_INV_PARK, -32768, -32768, 0,
                                          1'b0, 0, -32768, -32768));
        pending_words.push_back(make_word(cpt_pkg::CMD_INV_PARK, -32768, 32767, 0,
                                          1'b0, 0, 32767, -32768));
        pending_words.push_back(make_word(cpt_pkg::CMD_PARK, 32767, 16384, -5,
                                          1'b1, 0, 32767, 0));
        pending_words.push_back(make_word(cpt_pkg::CMD_PARK, 32767, 16384, 0,
                                          1'b1, 16384, 0, 0));
        pending_words.push_back(make_word(cpt_pkg::CMD_PARK, -32768, 32767, 0,
                                          1'b1, 32768, 0, 0));
        pending_words.push_back(make_word(cpt_pkg::CMD_PARK, 12345, -23456, 0,
                                          1'b1, 49152, 0, 0));
        pending_words.push_back(make_word(cpt_pkg::CMD_PARK, 32767, 32767, 0,
                                          1'b1, 65535, 0, 0));
        pending_words.push_back(make_word(cpt_pkg::CMD_INV_PARK, 32767, -32768, 0,
                                          1'b1, 8192, 0, 0));
        pending_words.push_back(make_word(cpt_pkg::CMD_INV_PARK, -32768, -32768, 0,
                                          1'b1, 16383, 0, 0));
        pending_words.push_back(make_word(cpt_pkg::CMD_INV_PARK, 20000, 10000, 0,
                                          1'b1, 40960, 0, 0));
        pending_words.push_back(make_word(cpt_pkg::CMD_INV_PARK, 32767, 32767, 0,
                                          1'b1, 57343, 0, 0));
        pending_words.push_back(make_word(cpt_pkg::CMD_PARK, 0, 0, 0,
                                          1'b0, 0, 0, 0));

        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            w.op          = cpt_pkg::cmd_t'($urandom_range(0, 3));
            w.a           = rand_sample();
            w.b           = rand_sample();
            w.c           = rand_sample();
            w.by_angle    = 1'($urandom_range(0, 1));
            w.angle       = rand_angle();
            w.sine        = rand_sample();
            w.cosine      = rand_sample();
            w.drain_first = ((i % 250) == 0);
            pending_words.push_back(w);
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_words.size() != 0 || in_valid || expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);

        if (mismatch_count == 0 && expected_results.size() == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
